>>> rtl/decimal_to_transposed_segment_rows_macros.svh
// Assertion macros shared by the decimal to segment-row block
`ifndef DECIMAL_TO_TRANSPOSED_SEGMENT_ROWS_MACROS_SVH
`define DECIMAL_TO_TRANSPOSED_SEGMENT_ROWS_MACROS_SVH

// Same-cycle implication, checked outside reset
`define DTSR_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("%m: implication check failed");

// Next-cycle implication, checked outside reset
`define DTSR_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("%m: next-cycle check failed");

`endif

>>> rtl/dtsr_pkg.sv
// Types, constants and the digit glyph table for the segment-row block
`default_nettype none

package dtsr_pkg;

   localparam int VALUE_W     = 32;
   localparam int BCD_DIGITS  = 10;
   localparam int BCD_W       = 4 * BCD_DIGITS;
   localparam int SHIFT_CNT_W = $clog2(VALUE_W);
   localparam int MAX_DIGITS  = 8;
   localparam int COUNT_W     = 4;
   localparam int ROW_COUNT   = 8;
   localparam int ROW_IDX_W   = $clog2(ROW_COUNT);
   localparam int ROW_W       = 8;
   localparam int POS_W       = $clog2(MAX_DIGITS) > 0 ? $clog2(MAX_DIGITS) : 1;
   localparam int GLYPH_SEGS  = 7;
   localparam int ADDR_W      = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIGIT_COUNT    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSITION_MASKS = 1'd1;

   localparam logic [COUNT_W-1:0]    DIGIT_COUNT_RESET = 4'd8;
   localparam logic [CSR_DATA_W-1:0] MASKS_RESET       = 64'h8040201008040201;
   localparam logic [ADDR_W-1:0]     ADDR_LAST         = 4'd8;
   localparam logic [3:0]            DIGIT_BLANK       = 4'hf;
   localparam logic [ROW_W-1:0]      ROW_CLEAR         = 8'h00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_PAINT,
      ST_EMIT
   } state_type;

   function automatic logic [GLYPH_SEGS-1:0] dtsr_glyph(input logic [3:0] digit);
      logic [GLYPH_SEGS-1:0] g;
      case (digit)
         4'd0:    g = 7'h3f;
         4'd1:    g = 7'h06;
         4'd2:    g = 7'h5b;
         4'd3:    g = 7'h4f;
         4'd4:    g = 7'h66;
         4'd5:    g = 7'h6d;
         4'd6:    g = 7'h7d;
         4'd7:    g = 7'h07;
         4'd8:    g = 7'h7f;
         4'd9:    g = 7'h6f;
         default: g = 7'h00;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

>>> rtl/dtsr_req_if.sv
// Number input channel: valid, ready and the value to show
`default_nettype none

interface dtsr_req_if;
   import dtsr_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/dtsr_rsp_if.sv
// Register write output channel: valid, ready, address, row data and last
`default_nettype none

interface dtsr_rsp_if;
   import dtsr_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] reg_address;
   logic [ROW_W-1:0]  reg_data;
   logic              last;

   modport source (output valid, output reg_address, output reg_data, output last,
                   input ready);
   modport sink   (input valid, input reg_address, input reg_data, input last,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/dtsr_dabble.sv
// Bit-serial binary to BCD converter, one input bit per cycle
`default_nettype none

module dtsr_dabble (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [dtsr_pkg::VALUE_W-1:0] value,
   output logic                             done,
   output logic [dtsr_pkg::BCD_W-1:0]       bcd
);
   import dtsr_pkg::*;

   logic [VALUE_W-1:0]     bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [SHIFT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [BCD_W-1:0]       adj;

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                    : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = value;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff + SHIFT_CNT_W'(1);
         if (cnt_ff == SHIFT_CNT_W'(VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

`default_nettype wire

>>> rtl/decimal_to_transposed_segment_rows.sv
// Decimal number to transposed seven-segment row writes, top level
//
//   channel   dir  handshake          payload
//   req_if    in   valid/ready        value[31:0]
//   rsp_if    out  valid/ready        reg_address[3:0], reg_data[7:0], last
//   csr_*     in   csr_we             csr_index[0:0], csr_wdata[63:0]
//
// A number passes through the serial BCD conversion and digit load, one paint
// step per digit to set the rows, the eight row writes and an idle state in
// which the next number is taken.
// Output back-pressure stretches the write phase; the next number is taken
// as soon as the eighth write sits in the output register.
// Reset is synchronous, active high; configuration returns to 8 digits and
// the default position masks.
`default_nettype none

`include "decimal_to_transposed_segment_rows_macros.svh"

module decimal_to_transposed_segment_rows (
   input  wire logic                            clock,
   input  wire logic                            reset,
   dtsr_req_if.sink                             req_if,
   dtsr_rsp_if.source                           rsp_if,
   input  wire logic                            csr_we,
   input  wire logic [dtsr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [dtsr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dtsr_pkg::*;

   state_type             state_ff, state_in;
   logic [COUNT_W-1:0]    digit_count_ff, digit_count_in;
   logic [CSR_DATA_W-1:0] masks_ff, masks_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    k_ff, k_in;
   logic [BCD_W-1:0]      digits_ff, digits_in;
   logic [ROW_W-1:0]      rows_ff [ROW_COUNT];
   logic [ROW_W-1:0]      rows_in [ROW_COUNT];
   logic [ROW_IDX_W-1:0]  emit_ff, emit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [ROW_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  start;
   logic                  dabble_done;
   logic [BCD_W-1:0]      dabble_bcd;
   logic                  load_out;
   logic [3:0]            digit_sel;
   logic [GLYPH_SEGS-1:0] glyph;
   logic [COUNT_W-1:0]    pos_full;
   logic [POS_W-1:0]      pos;
   logic [ROW_W-1:0]      mask;
   logic                  rows_any;
   logic                  emit_done;

   dtsr_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (start),
      .value (req_if.value),
      .done  (dabble_done),
      .bcd   (dabble_bcd)
   );

   // configuration registers
   always_comb begin
      digit_count_in = digit_count_ff;
      masks_in       = masks_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DIGIT_COUNT:    digit_count_in = csr_wdata[COUNT_W-1:0];
            CSR_POSITION_MASKS: masks_in       = csr_wdata;
            default:            ;
         endcase
      end
   end

   assign digit_sel = (k_ff != '0 && digits_ff == '0) ? DIGIT_BLANK : digits_ff[3:0];
   assign glyph     = dtsr_glyph(digit_sel);
   assign pos_full  = count_ff - COUNT_W'(1) - k_ff;
   assign pos       = pos_full[POS_W-1:0];
   assign mask      = masks_ff[{pos, 3'b000} +: ROW_W];
   assign load_out  = !rsp_valid_ff || rsp_if.ready;
   assign emit_done = (state_ff == ST_EMIT) && load_out &&
                      (emit_ff == ROW_IDX_W'(ROW_COUNT - 1));

   always_comb begin
      rows_any = 1'b0;
      for (int i = 0; i < ROW_COUNT; i++) begin
         rows_any = rows_any | (rows_ff[i] != ROW_CLEAR);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      digits_in    = digits_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rows_in      = rows_ff;
      start        = 1'b0;
      req_if.ready = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               start    = 1'b1;
               count_in = (digit_count_ff > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS)
                                                                 : digit_count_ff;
               k_in     = '0;
               emit_in  = '0;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (dabble_done) begin
               digits_in = dabble_bcd;
               state_in  = (count_ff == '0) ? ST_EMIT : ST_PAINT;
            end
         end
         ST_PAINT: begin
            for (int s = 0; s < GLYPH_SEGS; s++) begin
               if (glyph[s]) begin
                  rows_in[s] = rows_ff[s] | mask;
               end
            end
            digits_in = {4'b0000, digits_ff[BCD_W-1:4]};
            k_in      = k_ff + COUNT_W'(1);
            if (k_ff == count_ff - COUNT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = ADDR_W'(emit_ff) + ADDR_W'(1);
               rsp_data_in  = rows_ff[0];
               rsp_last_in  = (emit_ff == ROW_IDX_W'(ROW_COUNT - 1));
               for (int i = 0; i < ROW_COUNT - 1; i++) begin
                  rows_in[i] = rows_ff[i+1];
               end
               rows_in[ROW_COUNT-1] = ROW_CLEAR;
               emit_in = emit_ff + ROW_IDX_W'(1);
               if (emit_ff == ROW_IDX_W'(ROW_COUNT - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         digit_count_ff <= DIGIT_COUNT_RESET;
         masks_ff       <= MASKS_RESET;
         k_ff           <= '0;
         emit_ff        <= '0;
         count_ff       <= '0;
         for (int i = 0; i < ROW_COUNT; i++) begin
            rows_ff[i] <= ROW_CLEAR;
         end
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         digit_count_ff <= digit_count_in;
         masks_ff       <= masks_in;
         k_ff           <= k_in;
         emit_ff        <= emit_in;
         count_ff       <= count_in;
         rows_ff        <= rows_in;
      end
      digits_ff   <= digits_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.reg_address = rsp_addr_ff;
   assign rsp_if.reg_data    = rsp_data_ff;
   assign rsp_if.last        = rsp_last_ff;

   `DTSR_ASSERT_IMPLIES(a_done_in_convert, clock, reset, dabble_done, state_ff == ST_CONVERT)
   `DTSR_ASSERT_IMPLIES(a_last_addr, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_addr_ff == ADDR_LAST)
   `DTSR_ASSERT_IMPLIES(a_paint_range, clock, reset, state_ff == ST_PAINT, k_ff < count_ff && count_ff <= COUNT_W'(MAX_DIGITS))
   `DTSR_ASSERT_NEXT(a_rows_cleared, clock, reset, emit_done, !rows_any)

endmodule

`default_nettype wire
